>>> sv/spectrum_bar_smoother_peak_marker_macros.svh
// assertion macros shared by the spectrum bar checker
`ifndef SPECTRUM_BAR_SMOOTHER_PEAK_MARKER_MACROS_SVH
`define SPECTRUM_BAR_SMOOTHER_PEAK_MARKER_MACROS_SVH

// same-cycle implication, disabled in reset
`define SBPM_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbpm same-cycle check failed");

// next-cycle implication, disabled in reset
`define SBPM_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbpm next-cycle check failed");

`endif

>>> sv/sbpm_pkg.sv
// types and constants of the spectrum bar smoother
package sbpm_pkg;

  // field widths
  localparam int IDX_W     = 7;
  localparam int MAG_W     = 8;
  localparam int ROW_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STYLE_MODE  = 2'd0,
    CFG_BASE_LEVEL  = 2'd1,
    CFG_MAG_SCALE   = 2'd2,
    CFG_FLOOR_LEVEL = 2'd3
  } cfg_reg_t;

  // style modes
  localparam logic [1:0] MODE_FALL   = 2'd0;
  localparam logic [1:0] MODE_BOUNCE = 2'd1;
  localparam logic [1:0] MODE_COARSE = 2'd2;

  // magnitude divisor selects
  localparam logic [1:0] SCALE_DIV1 = 2'd0;
  localparam logic [1:0] SCALE_DIV2 = 2'd1;
  localparam logic [1:0] SCALE_DIV3 = 2'd2;

  // reset values of the registers
  localparam logic [1:0]       RST_STYLE_MODE  = MODE_FALL;
  localparam logic [ROW_W-1:0] RST_BASE_LEVEL  = 8'd64;
  localparam logic [1:0]       RST_MAG_SCALE   = SCALE_DIV2;
  localparam logic [ROW_W-1:0] RST_FLOOR_LEVEL = 8'd2;

  // divide by three as multiply by 171 and shift by 9, exact for 8-bit values
  localparam logic [7:0] RECIP_DIV3  = 8'd171;
  localparam int         RECIP_SHIFT = 9;

  // bar move thresholds
  localparam logic [3:0] THR_BIG_FINE   = 4'd6;
  localparam logic [3:0] THR_MID_FINE   = 4'd2;
  localparam logic [3:0] THR_SML_FALL   = 4'd1;
  localparam logic [3:0] THR_SML_BOUNCE = 4'd0;
  localparam logic [3:0] THR_BIG_COARSE = 4'd10;
  localparam logic [3:0] THR_MID_COARSE = 4'd3;
  localparam logic [3:0] THR_SML_COARSE = 4'd0;

  // bar move steps
  localparam logic [2:0] STEP_BIG = 3'd4;
  localparam logic [2:0] STEP_MID = 3'd2;
  localparam logic [2:0] STEP_SML = 3'd1;

  // marker offsets
  localparam logic [ROW_W-1:0] MARK_GAP      = 8'd3;
  localparam logic [ROW_W-1:0] MARK_DROP_MIN = 8'd4;
  localparam logic [ROW_W-1:0] MARK_FALL     = 8'd1;
  localparam logic [ROW_W-1:0] MARK_RISE     = 8'd2;

  // one stored bar entry
  typedef struct packed {
    logic             bounce;
    logic [ROW_W-1:0] marker;
    logic [ROW_W-1:0] bar;
  } bar_entry_t;

endpackage

>>> sv/sbpm_if.sv
// stream interfaces for bin samples and bar results
interface sbpm_in_if import sbpm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] bar_index;
  logic [MAG_W-1:0] magnitude;

  modport source (output valid, output bar_index, output magnitude, input ready);
  modport sink   (input valid, input bar_index, input magnitude, output ready);
endinterface

interface sbpm_out_if import sbpm_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] bar_echo;
  logic [ROW_W-1:0] bar_row;
  logic [ROW_W-1:0] marker_row;

  modport source (output valid, output bar_echo, output bar_row, output marker_row,
                  input ready);
  modport sink   (input valid, input bar_echo, input bar_row, input marker_row,
                  output ready);
endinterface

>>> sv/spectrum_bar_smoother_peak_marker.sv
// spectrum bar falloff with peak marker, top level
// path: an accepted beat goes into the input register and then into the result register
// throughput: one beat per cycle unless the output stalls, set by the registered read
//   of the bar memory and one update stage, which forwards to a next beat on the same bar
// reset: registers take their reset values, per-bar valid bits clear at once so every
//   bar, marker and bounce flag reads as zero, no clearing pass
module spectrum_bar_smoother_peak_marker import sbpm_pkg::*; #(
  parameter int BAR_COUNT = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  sbpm_in_if.sink              in_ch,
  sbpm_out_if.source           out_ch
);

  localparam int AW = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
  localparam int WW = AW + IDX_W;

  // configuration registers
  logic [1:0]       mode_r;
  logic [ROW_W-1:0] base_r;
  logic [1:0]       scale_r;
  logic [ROW_W-1:0] floor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= RST_STYLE_MODE;
      base_r  <= RST_BASE_LEVEL;
      scale_r <= RST_MAG_SCALE;
      floor_r <= RST_FLOOR_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_STYLE_MODE:  mode_r  <= cfg_data[1:0];
        CFG_BASE_LEVEL:  base_r  <= cfg_data[ROW_W-1:0];
        CFG_MAG_SCALE:   scale_r <= cfg_data[1:0];
        CFG_FLOOR_LEVEL: floor_r <= cfg_data[ROW_W-1:0];
      endcase
    end
  end

  // pipeline control
  logic             s1_v_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic [MAG_W-1:0] s1_mag_r;
  logic             s1_hit_r;
  logic             out_v_r;
  logic             adv;
  logic             acc;
  logic             s1_wr;

  assign adv         = !out_v_r || out_ch.ready;
  assign in_ch.ready = !s1_v_r || adv;
  assign acc         = in_ch.valid && in_ch.ready;

  // address decode of the incoming and the working beat
  logic [WW-1:0] in_wide;
  logic [WW-1:0] s1_wide;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] s1_addr;
  logic          in_hit;

  assign in_wide = {{AW{1'b0}}, in_ch.bar_index};
  assign s1_wide = {{AW{1'b0}}, s1_idx_r};
  assign in_addr = in_wide[AW-1:0];
  assign s1_addr = s1_wide[AW-1:0];
  assign in_hit  = in_wide < WW'(BAR_COUNT);
  assign s1_wr   = s1_v_r && adv && s1_hit_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (acc) begin
      s1_v_r <= 1'b1;
    end else if (adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_idx_r <= in_ch.bar_index;
      s1_mag_r <= in_ch.magnitude;
      s1_hit_r <= in_hit;
    end
  end

  // bar memory with registered read and forwarding of the entry written this cycle
  bar_entry_t mem [BAR_COUNT];
  logic       vld_r [BAR_COUNT];
  bar_entry_t rd_r;
  logic       rd_vld_r;
  logic       byp_r;
  bar_entry_t byp_data_r;
  bar_entry_t ent_nxt;

  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem[s1_addr] <= ent_nxt;
    end
    if (acc) begin
      rd_r       <= mem[in_addr];
      rd_vld_r   <= vld_r[in_addr];
      byp_r      <= s1_wr && (s1_addr == in_addr);
      byp_data_r <= ent_nxt;
    end
  end

  // per-bar valid bits, unwritten bars read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BAR_COUNT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (s1_wr) begin
      vld_r[s1_addr] <= 1'b1;
    end
  end

  // mode decode
  logic       is_fall;
  logic       is_bounce;
  logic [3:0] thr_big;
  logic [3:0] thr_mid;
  logic [3:0] thr_sml;

  always_comb begin
    unique case (mode_r)
      MODE_FALL: begin
        is_fall = 1'b1; is_bounce = 1'b0;
        thr_big = THR_BIG_FINE; thr_mid = THR_MID_FINE; thr_sml = THR_SML_FALL;
      end
      MODE_BOUNCE: begin
        is_fall = 1'b0; is_bounce = 1'b1;
        thr_big = THR_BIG_FINE; thr_mid = THR_MID_FINE; thr_sml = THR_SML_BOUNCE;
      end
      default: begin
        is_fall = 1'b0; is_bounce = 1'b0;
        thr_big = THR_BIG_COARSE; thr_mid = THR_MID_COARSE; thr_sml = THR_SML_COARSE;
      end
    endcase
  end

  // target row from scaled magnitude
  logic [15:0]      prod3;
  logic [ROW_W-1:0] qmag;
  logic [ROW_W-1:0] diff;
  logic [ROW_W-1:0] tgt;

  assign prod3 = 16'(s1_mag_r) * 16'(RECIP_DIV3);
  assign diff  = base_r - qmag;

  always_comb begin
    case (scale_r)
      SCALE_DIV1: qmag = s1_mag_r;
      SCALE_DIV2: qmag = {1'b0, s1_mag_r[MAG_W-1:1]};
      default:    qmag = ROW_W'(prod3 >> RECIP_SHIFT);
    endcase
    if (base_r < qmag || diff < floor_r) begin
      tgt = floor_r;
    end else begin
      tgt = diff;
    end
  end

  // bar moves toward target, first up then down
  bar_entry_t cur;
  logic [9:0] bw;
  logic [9:0] tw;
  logic [9:0] b1;
  logic [9:0] b2;
  logic [ROW_W-1:0] bar_new;

  assign cur = byp_r ? byp_data_r : (rd_vld_r ? rd_r : '0);
  assign bw  = 10'(cur.bar);
  assign tw  = 10'(tgt);

  always_comb begin
    if (bw + 10'(thr_big) < tw) begin
      b1 = bw + 10'(STEP_BIG);
    end else if (bw + 10'(thr_mid) < tw) begin
      b1 = bw + 10'(STEP_MID);
    end else if (bw + 10'(thr_sml) < tw) begin
      b1 = bw + 10'(STEP_SML);
    end else begin
      b1 = bw;
    end
    if (b1 > tw + 10'(thr_big)) begin
      b2 = b1 - 10'(STEP_BIG);
    end else if (b1 > tw + 10'(thr_mid)) begin
      b2 = b1 - 10'(STEP_MID);
    end else if (b1 > tw + 10'(thr_sml)) begin
      b2 = b1 - 10'(STEP_SML);
    end else begin
      b2 = b1;
    end
  end

  assign bar_new = b2[ROW_W-1:0];

  // marker trails the bar, bounce flag in bounce mode
  logic [ROW_W:0]   mk3;
  logic [ROW_W:0]   barw;
  logic [ROW_W-1:0] mk_new;
  logic             fl_new;

  assign mk3  = {1'b0, cur.marker} + {1'b0, MARK_GAP};
  assign barw = {1'b0, bar_new};

  always_comb begin
    mk_new = cur.marker;
    fl_new = cur.bounce;
    if (is_fall || is_bounce) begin
      if (mk3 > barw) begin
        mk_new = (bar_new >= MARK_GAP) ? bar_new - MARK_GAP : '0;
        if (is_bounce) begin
          fl_new = 1'b0;
        end
      end else if (mk3 < barw) begin
        if (is_fall) begin
          mk_new = cur.marker + MARK_FALL;
        end else if (!cur.bounce) begin
          if (cur.marker >= MARK_DROP_MIN) begin
            mk_new = cur.marker - MARK_GAP;
          end else if (cur.marker != '0) begin
            fl_new = 1'b1;
          end else begin
            mk_new = cur.marker + MARK_RISE;
          end
        end else begin
          mk_new = cur.marker + MARK_RISE;
        end
      end
    end
  end

  assign ent_nxt = '{bounce: fl_new, marker: mk_new, bar: bar_new};

  // result register
  logic [IDX_W-1:0] out_echo_r;
  logic [ROW_W-1:0] out_bar_r;
  logic [ROW_W-1:0] out_mk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_v_r) begin
      out_echo_r <= s1_idx_r;
      out_bar_r  <= s1_hit_r ? bar_new : '0;
      out_mk_r   <= (s1_hit_r && (is_fall || is_bounce)) ? mk_new : '0;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.bar_echo   = out_echo_r;
  assign out_ch.bar_row    = out_bar_r;
  assign out_ch.marker_row = out_mk_r;

endmodule

>>> sv/sbpm_checker.sv
// port-level checks of the spectrum bar smoother and their bind
`include "spectrum_bar_smoother_peak_marker_macros.svh"

module sbpm_checker import sbpm_pkg::*; #(
  parameter int BAR_COUNT = 128
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] bar_echo,
  input logic [ROW_W-1:0] bar_row,
  input logic [ROW_W-1:0] marker_row
);

  // result beat for a bar index beyond the bar count
  logic beyond_count;
  logic rows_zero;

  assign beyond_count = out_valid && (9'(bar_echo) >= 9'(BAR_COUNT));
  assign rows_zero    = (bar_row == '0) && (marker_row == '0);

  // a stalled result beat stays offered
  `SBPM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // with the result register empty the block always takes a beat
  `SBPM_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

  // a bar index beyond the bar count gives zero rows
  `SBPM_ASSERT_IMP(a_out_of_range_zero, clk, rst_n, beyond_count, rows_zero)

  // the marker never sits below the bar top
  `SBPM_ASSERT_IMP(a_marker_above_bar, clk, rst_n, out_valid, marker_row <= bar_row)

endmodule

bind spectrum_bar_smoother_peak_marker sbpm_checker #(.BAR_COUNT(BAR_COUNT)) u_sbpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .bar_echo   (out_ch.bar_echo),
  .bar_row    (out_ch.bar_row),
  .marker_row (out_ch.marker_row)
);

>>> tb/sv/sbpm_bar_checker.sv
// bar and marker row predictor and result comparison for the spectrum bar smoother
module sbpm_bar_checker import sbpm_pkg::*; #(
  parameter int BAR_COUNT = 128
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  sbpm_in_if                   in_ch,
  sbpm_out_if                  out_ch,
  output int                   pending_beats,
  output int                   mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] bar_echo;
    logic [ROW_W-1:0] bar_row;
    logic [ROW_W-1:0] marker_row;
  } bar_result_t;

  // predicted rows still waiting for their result beat
  bar_result_t expected_rows_q[$];
  int          error_total = 0;

  // own copy of the registers
  logic [1:0]       mode_r;
  logic [ROW_W-1:0] base_r;
  logic [1:0]       scale_r;
  logic [ROW_W-1:0] floor_r;

  // own copy of the per-bar state
  logic [ROW_W-1:0] bar_level    [BAR_COUNT];
  logic [ROW_W-1:0] marker_level [BAR_COUNT];
  logic             bounce_set   [BAR_COUNT];

  // moves the bar toward its target, lets the marker trail, updates the state
  function automatic bar_result_t smooth_bar(logic [IDX_W-1:0] idx, logic [MAG_W-1:0] mag);
    bar_result_t res;
    int divisor;
    int goal;
    int level;
    int mark;
    int big;
    int mid;
    int sml;
    res.bar_echo   = idx;
    res.bar_row    = '0;
    res.marker_row = '0;
    if (int'(idx) >= BAR_COUNT) return res;

    // scaled magnitude below the base level, held at the floor
    case (scale_r)
      SCALE_DIV1: divisor = 1;
      SCALE_DIV2: divisor = 2;
      default:    divisor = 3;
    endcase
    goal = int'(base_r) - int'(mag) / divisor;
    if (goal < int'(floor_r)) goal = int'(floor_r);

    // thresholds per style, codes above coarse act as coarse
    case (mode_r)
      MODE_FALL: begin
        big = int'(THR_BIG_FINE);
        mid = int'(THR_MID_FINE);
        sml = int'(THR_SML_FALL);
      end
      MODE_BOUNCE: begin
        big = int'(THR_BIG_FINE);
        mid = int'(THR_MID_FINE);
        sml = int'(THR_SML_BOUNCE);
      end
      default: begin
        big = int'(THR_BIG_COARSE);
        mid = int'(THR_MID_COARSE);
        sml = int'(THR_SML_COARSE);
      end
    endcase

    level = int'(bar_level[idx]);
    if (level + big < goal)      level = level + int'(STEP_BIG);
    else if (level + mid < goal) level = level + int'(STEP_MID);
    else if (level + sml < goal) level = level + int'(STEP_SML);
    if (level > goal + big)      level = level - int'(STEP_BIG);
    else if (level > goal + mid) level = level - int'(STEP_MID);
    else if (level > goal + sml) level = level - int'(STEP_SML);
    bar_level[idx] = ROW_W'(level);
    res.bar_row    = ROW_W'(level);

    // coarse style keeps no marker and leaves its state alone
    if (mode_r != MODE_FALL && mode_r != MODE_BOUNCE) return res;

    mark = int'(marker_level[idx]);
    if (mark + int'(MARK_GAP) > level) begin
      // marker pulled to the gap above the bar, clamped at row zero
      mark = (level >= int'(MARK_GAP)) ? level - int'(MARK_GAP) : 0;
      if (mode_r == MODE_BOUNCE) bounce_set[idx] = 1'b0;
    end else if (mark + int'(MARK_GAP) < level) begin
      if (mode_r == MODE_FALL) begin
        mark = mark + int'(MARK_FALL);
      end else if (!bounce_set[idx]) begin
        if (mark >= int'(MARK_DROP_MIN)) mark = mark - int'(MARK_GAP);
        else if (mark != 0)              bounce_set[idx] = 1'b1;
        else                             mark = mark + int'(MARK_RISE);
      end else begin
        mark = mark + int'(MARK_RISE);
      end
    end
    marker_level[idx] = ROW_W'(mark);
    res.marker_row    = ROW_W'(mark);
    return res;
  endfunction

  // watch config writes, input beats and result beats
  always @(posedge clk) begin
    bar_result_t seen;
    bar_result_t want;
    if (!rst_n) begin
      mode_r  = RST_STYLE_MODE;
      base_r  = RST_BASE_LEVEL;
      scale_r = RST_MAG_SCALE;
      floor_r = RST_FLOOR_LEVEL;
      for (int i = 0; i < BAR_COUNT; i++) begin
        bar_level[i]    = '0;
        marker_level[i] = '0;
        bounce_set[i]   = 1'b0;
      end
      expected_rows_q.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        seen.bar_echo   = out_ch.bar_echo;
        seen.bar_row    = out_ch.bar_row;
        seen.marker_row = out_ch.marker_row;
        if (expected_rows_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: bar %0d row %0d marker %0d",
                   $time, seen.bar_echo, seen.bar_row, seen.marker_row);
          error_total++;
        end else begin
          want = expected_rows_q.pop_front();
          if (seen.bar_echo !== want.bar_echo || seen.bar_row !== want.bar_row ||
              seen.marker_row !== want.marker_row) begin
            $display("%0t: row mismatch: expected bar %0d row %0d marker %0d, actual bar %0d row %0d marker %0d",
                     $time, want.bar_echo, want.bar_row, want.marker_row,
                     seen.bar_echo, seen.bar_row, seen.marker_row);
            error_total++;
          end
        end
      end

      // register writes
      if (cfg_we) begin
        case (cfg_index)
          CFG_STYLE_MODE:  mode_r  = cfg_data[1:0];
          CFG_BASE_LEVEL:  base_r  = cfg_data;
          CFG_MAG_SCALE:   scale_r = cfg_data[1:0];
          CFG_FLOOR_LEVEL: floor_r = cfg_data;
          default: ;
        endcase
      end

      // input beat
      if (in_ch.valid && in_ch.ready)
        expected_rows_q.push_back(smooth_bar(in_ch.bar_index, in_ch.magnitude));
    end
    pending_beats  <= expected_rows_q.size();
    mismatch_count <= error_total;
  end

endmodule

>>> tb/sv/testbench.sv
// top of the spectrum bar smoother testbench: clock, reset, stimulus and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sbpm_pkg::*;

  localparam int BAR_COUNT    = 128;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOT_COUNT    = 4;

  // codes beyond the named ones, aliases of coarse style and divide by three
  localparam logic [1:0] MODE_ALIAS  = 2'd3;
  localparam logic [1:0] SCALE_ALIAS = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   pending_beats;
  int                   mismatch_count;
  int                   cycle_cnt = 0;

  // bars that get long runs of samples, each with a drifting magnitude
  logic [IDX_W-1:0] hot_bars [HOT_COUNT];
  logic [MAG_W-1:0] hot_mags [HOT_COUNT];

  sbpm_in_if  in_bus ();
  sbpm_out_if out_bus ();

  spectrum_bar_smoother_peak_marker #(
    .BAR_COUNT (BAR_COUNT)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  sbpm_bar_checker #(
    .BAR_COUNT (BAR_COUNT)
  ) i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_ch          (in_bus),
    .out_ch         (out_bus),
    .pending_beats  (pending_beats),
    .mismatch_count (mismatch_count)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // result side stalls, with the stall pattern picked again at random
  initial begin
    int stall_style;
    int style_left;
    stall_style    = 0;
    style_left     = 0;
    out_bus.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(20, 200);
      end
      style_left--;
      case (stall_style)
        0:       out_bus.ready <= 1'b1;
        1:       out_bus.ready <= ($urandom_range(0, 3) != 0);
        2:       out_bus.ready <= ((style_left % 7) >= 3);
        default: out_bus.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // one input beat, returns after the edge that takes it
  task automatic send_beat(input logic [IDX_W-1:0] idx, input logic [MAG_W-1:0] mag);
    in_bus.valid     <= 1'b1;
    in_bus.bar_index <= idx;
    in_bus.magnitude <= mag;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // stop sending and wait until every predicted row has come back
  task automatic settle();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // all four registers back to back
  task automatic program_regs(input logic [1:0] mode, input logic [ROW_W-1:0] base,
                              input logic [1:0] scale, input logic [ROW_W-1:0] floor_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_STYLE_MODE;
    cfg_data  <= CFG_W'(mode);
    @(posedge clk);
    cfg_index <= CFG_BASE_LEVEL;
    cfg_data  <= base;
    @(posedge clk);
    cfg_index <= CFG_MAG_SCALE;
    cfg_data  <= CFG_W'(scale);
    @(posedge clk);
    cfg_index <= CFG_FLOOR_LEVEL;
    cfg_data  <= floor_v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly steady runs on a few bars, the rest random noise
  task automatic pick_sample(output logic [IDX_W-1:0] idx, output logic [MAG_W-1:0] mag);
    int k;
    if ($urandom_range(0, 9) < 7) begin
      k = $urandom_range(0, HOT_COUNT - 1);
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0:       hot_mags[k] = '0;
          1:       hot_mags[k] = '1;
          default: hot_mags[k] = MAG_W'($urandom_range(0, 255));
        endcase
      end
      idx = hot_bars[k];
      mag = hot_mags[k] ^ MAG_W'($urandom_range(0, 3));
    end else begin
      idx = IDX_W'($urandom_range(0, BAR_COUNT - 1));
      mag = MAG_W'($urandom_range(0, 255));
    end
  endtask

  // stimulus
  initial begin
    logic [IDX_W-1:0] idx;
    logic [MAG_W-1:0] mag;
    logic [1:0]       mode_v;
    logic [1:0]       scale_v;
    logic [ROW_W-1:0] base_v;
    logic [ROW_W-1:0] floor_v;
    int               left;
    int               burst;
    int               gap;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_STYLE_MODE;
    cfg_data         = '0;
    in_bus.valid     = 1'b0;
    in_bus.bar_index = '0;
    in_bus.magnitude = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: climb from zero, marker held at row zero, both end bars
    send_beat(IDX_W'(0), MAG_W'(0));
    send_beat(IDX_W'(0), MAG_W'(0));
    send_beat(IDX_W'(0), MAG_W'(0));
    send_beat(IDX_W'(0), MAG_W'(255));
    send_beat(IDX_W'(127), MAG_W'(255));
    send_beat(IDX_W'(127), MAG_W'(0));
    repeat (3) send_beat(IDX_W'(5), MAG_W'(0));
    settle();

    // bounce style, full range target, then a target at the top
    program_regs(MODE_BOUNCE, ROW_W'(255), SCALE_DIV1, ROW_W'(0));
    repeat (8) send_beat(IDX_W'(1), MAG_W'(0));
    repeat (2) send_beat(IDX_W'(1), MAG_W'(255));
    settle();

    // coarse style, target held by a high floor
    program_regs(MODE_COARSE, ROW_W'(200), SCALE_DIV3, ROW_W'(255));
    repeat (2) send_beat(IDX_W'(2), MAG_W'(128));
    send_beat(IDX_W'(0), MAG_W'(77));
    settle();

    // unnamed style and scale codes
    program_regs(MODE_ALIAS, ROW_W'(0), SCALE_ALIAS, ROW_W'(0));
    send_beat(IDX_W'(3), MAG_W'(255));
    send_beat(IDX_W'(0), MAG_W'(1));
    settle();

    // random phases, each with its own settings, busy bars partly picked anew
    for (int ph = 0; ph < 10; ph++) begin
      mode_v  = 2'(ph % 4);
      scale_v = 2'($urandom_range(0, 3));
      base_v  = ($urandom_range(0, 4) == 0) ? ROW_W'(255) : ROW_W'($urandom_range(40, 255));
      case ($urandom_range(0, 5))
        0:       floor_v = ROW_W'(0);
        1:       floor_v = ROW_W'($urandom_range(0, 255));
        default: floor_v = ROW_W'($urandom_range(0, 30));
      endcase
      program_regs(mode_v, base_v, scale_v, floor_v);
      for (int k = 0; k < HOT_COUNT; k++) begin
        if (ph == 0 || $urandom_range(0, 2) == 0) begin
          hot_bars[k] = IDX_W'($urandom_range(0, BAR_COUNT - 1));
          hot_mags[k] = MAG_W'($urandom_range(0, 255));
        end
      end

      left = $urandom_range(95, 110);
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        if (burst > left) burst = left;
        repeat (burst) begin
          pick_sample(idx, mag);
          send_beat(idx, mag);
        end
        left -= burst;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0 && left > 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
